// ----- rtl/spfp_pkg.sv -----
// ----------------------------------------------------------------------------
// spfp_pkg
// Shared types and constants of the sensor packet field parser.
// ----------------------------------------------------------------------------
package spfp_pkg;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_SET     = 4'd2,
        PH_LEN     = 4'd3,
        PH_FLEN    = 4'd4,
        PH_FDESC   = 4'd5,
        PH_FDATA   = 4'd6,
        PH_SKIP    = 4'd7,
        PH_TRAILER = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        K_ACK      = 4'd0,
        K_FLOAT3   = 4'd1,
        K_DOUBLE3  = 4'd2,
        K_FLOAT3A  = 4'd3,
        K_TIME     = 4'd4,
        K_UNKNOWN  = 4'd5,
        K_BAD_SET  = 4'd6,
        K_SYNC_ERR = 4'd7,
        K_BAD_LEN  = 4'd8
    } t_kind;

    localparam logic [7:0] SYNC1      = 8'h75;
    localparam logic [7:0] SYNC2      = 8'h65;
    localparam logic [7:0] DESC_ACK   = 8'hf1;
    localparam logic [7:0] SET_NAV    = 8'h80;
    localparam logic [7:0] SET_GPS    = 8'h81;
    localparam logic [7:0] SET_AUX    = 8'h0c;
    localparam logic [7:0] DESC_AUX   = 8'h9b;
    localparam logic [7:0] DESC_TIME  = 8'h0e;
    localparam logic [7:0] DESC_LLH   = 8'h04;
    localparam logic [7:0] DESC_NED   = 8'h06;
    localparam logic [7:0] DESC_MAX1  = 8'h08;

    // Buffered bytes needed by any record kind (up to the flags of the double record).
    localparam int USED_BYTES = 30;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  set_desc;
        logic [7:0]  field_desc;
        logic        last;
    } t_event;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  set_desc;
        logic [7:0]  field_desc;
        logic [63:0] x_bits;
        logic [63:0] y_bits;
        logic [63:0] z_bits;
        logic [31:0] accuracy_bits;
        logic [15:0] valid_flags;
        logic [31:0] tick_count;
        logic [7:0]  ack_echo;
        logic [7:0]  ack_error;
        logic        last;
    } t_record;

endpackage

// ----- rtl/sensor_packet_field_parser.sv -----
// ----------------------------------------------------------------------------
// sensor_packet_field_parser
// Byte-serial parser for sync-framed sensor packets, one record per field.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while full is low. A record reaches the result
// side through a four-entry event queue and an output register; full rises
// only when that queue fills behind a stalled result side.
module sensor_packet_field_parser #(
    parameter int FIELD_BUF_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_record_kind,
    output logic [7:0]  o_set_desc,
    output logic [7:0]  o_field_desc,
    output logic [63:0] o_x_bits,
    output logic [63:0] o_y_bits,
    output logic [63:0] o_z_bits,
    output logic [31:0] o_accuracy_bits,
    output logic [15:0] o_valid_flags,
    output logic [31:0] o_tick_count,
    output logic [7:0]  o_ack_echo,
    output logic [7:0]  o_ack_error,
    output logic        o_last_in_packet
);

    localparam int UB = spfp_pkg::USED_BYTES;
    localparam int QW = $bits(spfp_pkg::t_event) + UB*8;

    logic                   ev_valid;
    spfp_pkg::t_event       ev;
    logic [UB*8-1:0]        ev_bytes;
    logic                   q_full, q_empty, back_ready, out_valid;
    logic [QW-1:0]          q_out;
    spfp_pkg::t_record      rec;

    assign full = q_full;

    spfp_front #(.FIELD_BUF_BYTES(FIELD_BUF_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(push && !q_full), .i_byte(i_rx_byte),
        .o_ev_valid(ev_valid), .o_ev(ev), .o_ev_bytes(ev_bytes)
    );

    spfp_queue #(.DEPTH(4), .WIDTH(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(ev_valid && push && !q_full),
        .i_data({ev, ev_bytes}), .o_full(q_full), .i_pop(back_ready),
        .o_empty(q_empty), .o_data(q_out)
    );

    spfp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!q_empty),
        .i_ev(spfp_pkg::t_event'(q_out[QW-1 -: $bits(spfp_pkg::t_event)])),
        .i_bytes(q_out[UB*8-1:0]), .o_ready(back_ready), .o_valid(out_valid),
        .o_rec(rec), .i_take(pop)
    );

    assign empty = !out_valid;
    assign o_record_kind = rec.kind;
    assign o_set_desc = rec.set_desc;
    assign o_field_desc = rec.field_desc;
    assign o_x_bits = rec.x_bits;
    assign o_y_bits = rec.y_bits;
    assign o_z_bits = rec.z_bits;
    assign o_accuracy_bits = rec.accuracy_bits;
    assign o_valid_flags = rec.valid_flags;
    assign o_tick_count = rec.tick_count;
    assign o_ack_echo = rec.ack_echo;
    assign o_ack_error = rec.ack_error;
    assign o_last_in_packet = rec.last;

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_record_kind == spfp_pkg::K_BAD_SET
                 || o_record_kind == spfp_pkg::K_SYNC_ERR
                 || o_record_kind == spfp_pkg::K_BAD_LEN)) |-> o_last_in_packet)
        else $error("error record without packet end");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_record_kind) && $stable(o_x_bits)))
        else $error("result changed while stalled");
    a_sync_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == spfp_pkg::K_SYNC_ERR) |-> (o_set_desc == 8'd0))
        else $error("sync error carries a set");

endmodule

// ----- rtl/spfp_front.sv -----
// ----------------------------------------------------------------------------
// spfp_front
// Framing state machine: hunts sync, walks fields, captures data bytes and
// raises one event per record together with a snapshot of the field bytes.
// ----------------------------------------------------------------------------
module spfp_front #(
    parameter int FIELD_BUF_BYTES = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [7:0]                           i_byte,
    output logic                                 o_ev_valid,
    output spfp_pkg::t_event                     o_ev,
    output logic [spfp_pkg::USED_BYTES*8-1:0]    o_ev_bytes
);

    localparam int UB = spfp_pkg::USED_BYTES;

    spfp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_set, n_set;
    logic [7:0] r_plen, n_plen;
    logic [7:0] r_ppos, n_ppos;
    logic [7:0] r_flen, n_flen;
    logic [7:0] r_fdesc, n_fdesc;
    logic [7:0] r_fpos, n_fpos;
    logic [1:0] r_tcnt, n_tcnt;
    logic [7:0] r_buf [UB];
    logic       clr_buf, wr_buf;
    logic [7:0] ppos_inc;
    logic       handled;
    logic       ev_valid;
    spfp_pkg::t_event ev;
    logic       ev_use_new;

    assign ppos_inc = r_ppos + 8'd1;
    assign handled = (r_set == spfp_pkg::SET_NAV) || (r_set == spfp_pkg::SET_GPS)
                  || (r_set == spfp_pkg::SET_AUX);

    always_comb begin
        n_phase = r_phase;
        n_set = r_set;
        n_plen = r_plen;
        n_ppos = r_ppos;
        n_flen = r_flen;
        n_fdesc = r_fdesc;
        n_fpos = r_fpos;
        n_tcnt = r_tcnt;
        clr_buf = 1'b0;
        wr_buf = 1'b0;
        ev_valid = 1'b0;
        ev_use_new = 1'b0;
        ev = '{kind: spfp_pkg::K_UNKNOWN, set_desc: r_set, field_desc: r_fdesc, last: 1'b0};
        if (i_valid) begin
            case (r_phase)
                spfp_pkg::PH_SYNC2: begin
                    if (i_byte == spfp_pkg::SYNC2) begin
                        n_phase = spfp_pkg::PH_SET;
                    end else begin
                        ev_valid = 1'b1;
                        ev = '{kind: spfp_pkg::K_SYNC_ERR, set_desc: 8'd0,
                               field_desc: 8'd0, last: 1'b1};
                        n_tcnt = 2'd0;
                        n_phase = spfp_pkg::PH_TRAILER;
                    end
                end
                spfp_pkg::PH_SET: begin
                    n_set = i_byte;
                    n_phase = spfp_pkg::PH_LEN;
                end
                spfp_pkg::PH_LEN: begin
                    n_plen = i_byte;
                    n_ppos = 8'd0;
                    n_tcnt = 2'd0;
                    n_phase = (i_byte == 8'd0) ? spfp_pkg::PH_TRAILER : spfp_pkg::PH_FLEN;
                end
                spfp_pkg::PH_FLEN: begin
                    n_ppos = ppos_inc;
                    n_flen = i_byte;
                    n_fdesc = 8'd0;
                    if (i_byte < 8'd2) begin
                        ev_valid = 1'b1;
                        ev = '{kind: spfp_pkg::K_BAD_LEN, set_desc: r_set,
                               field_desc: 8'd0, last: 1'b1};
                        n_tcnt = 2'd0;
                        n_phase = (ppos_inc == r_plen) ? spfp_pkg::PH_TRAILER
                                                       : spfp_pkg::PH_SKIP;
                    end else begin
                        clr_buf = 1'b1;
                        n_fpos = 8'd0;
                        if (ppos_inc == r_plen) begin
                            n_tcnt = 2'd0;
                            n_phase = spfp_pkg::PH_TRAILER;
                        end else begin
                            n_phase = spfp_pkg::PH_FDESC;
                        end
                    end
                end
                spfp_pkg::PH_FDESC: begin
                    n_ppos = ppos_inc;
                    n_fdesc = i_byte;
                    if (i_byte != spfp_pkg::DESC_ACK && !handled) begin
                        ev_valid = 1'b1;
                        ev = '{kind: spfp_pkg::K_BAD_SET, set_desc: r_set,
                               field_desc: i_byte, last: 1'b1};
                        n_tcnt = 2'd0;
                        n_phase = (ppos_inc == r_plen) ? spfp_pkg::PH_TRAILER
                                                       : spfp_pkg::PH_SKIP;
                    end else if (r_flen == 8'd2 || ppos_inc == r_plen) begin
                        ev_valid = 1'b1;
                        ev = '{kind: spfp_pkg::K_UNKNOWN, set_desc: r_set,
                               field_desc: i_byte, last: (ppos_inc == r_plen)};
                        n_tcnt = 2'd0;
                        n_phase = (ppos_inc == r_plen) ? spfp_pkg::PH_TRAILER
                                                       : spfp_pkg::PH_FLEN;
                    end else begin
                        n_phase = spfp_pkg::PH_FDATA;
                    end
                end
                spfp_pkg::PH_FDATA: begin
                    n_ppos = ppos_inc;
                    wr_buf = 1'b1;
                    n_fpos = r_fpos + 8'd1;
                    if ({1'b0, n_fpos} + 9'd2 >= {1'b0, r_flen} || ppos_inc == r_plen) begin
                        ev_valid = 1'b1;
                        ev_use_new = 1'b1;
                        ev = '{kind: spfp_pkg::K_UNKNOWN, set_desc: r_set,
                               field_desc: r_fdesc, last: (ppos_inc == r_plen)};
                        n_tcnt = 2'd0;
                        n_phase = (ppos_inc == r_plen) ? spfp_pkg::PH_TRAILER
                                                       : spfp_pkg::PH_FLEN;
                    end
                end
                spfp_pkg::PH_SKIP: begin
                    n_ppos = ppos_inc;
                    if (ppos_inc == r_plen) begin
                        n_tcnt = 2'd0;
                        n_phase = spfp_pkg::PH_TRAILER;
                    end
                end
                spfp_pkg::PH_TRAILER: begin
                    n_tcnt = r_tcnt + 2'd1;
                    if (r_tcnt + 2'd1 >= 2'd2) begin
                        n_tcnt = 2'd0;
                        n_phase = spfp_pkg::PH_HUNT;
                    end
                end
                default: begin
                    n_phase = (i_byte == spfp_pkg::SYNC1) ? spfp_pkg::PH_SYNC2
                                                          : spfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spfp_pkg::PH_HUNT;
            r_set <= 8'd0;
            r_plen <= 8'd0;
            r_ppos <= 8'd0;
            r_flen <= 8'd0;
            r_fdesc <= 8'd0;
            r_fpos <= 8'd0;
            r_tcnt <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_set <= n_set;
            r_plen <= n_plen;
            r_ppos <= n_ppos;
            r_flen <= n_flen;
            r_fdesc <= n_fdesc;
            r_fpos <= n_fpos;
            r_tcnt <= n_tcnt;
        end
    end

    // Bytes past the buffer size are counted but never stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_buf) begin
            for (int k = 0; k < UB; k++) begin
                r_buf[k] <= 8'd0;
            end
        end else if (wr_buf) begin
            for (int k = 0; k < UB; k++) begin
                if (r_fpos == 8'(k) && k < FIELD_BUF_BYTES) begin
                    r_buf[k] <= i_byte;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < UB; k++) begin
            o_ev_bytes[(UB-1-k)*8 +: 8] = r_buf[k];
            if (ev_use_new && r_fpos == 8'(k) && k < FIELD_BUF_BYTES) begin
                o_ev_bytes[(UB-1-k)*8 +: 8] = i_byte;
            end
        end
    end

    assign o_ev_valid = ev_valid;
    assign o_ev = ev;

endmodule

// ----- rtl/spfp_queue.sv -----
// ----------------------------------------------------------------------------
// spfp_queue
// Small register queue of raw events between framing and record decode.
// ----------------------------------------------------------------------------
module spfp_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(r_cnt > (AW+1)'(DEPTH)))
        else $error("queue count beyond depth");
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not drop on pop");
    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not rise on push");

endmodule

// ----- rtl/spfp_back.sv -----
// ----------------------------------------------------------------------------
// spfp_back
// Record decode: classifies the field and slices big-endian values out of
// the captured bytes into an output register stage.
// ----------------------------------------------------------------------------
module spfp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  spfp_pkg::t_event                  i_ev,
    input  logic [spfp_pkg::USED_BYTES*8-1:0] i_bytes,
    output logic                              o_ready,
    output logic                              o_valid,
    output spfp_pkg::t_record                 o_rec,
    input  logic                              i_take
);

    localparam int UB = spfp_pkg::USED_BYTES;

    spfp_pkg::t_record rec;
    spfp_pkg::t_record r_rec;
    logic              r_valid;
    logic [7:0]        s, d;

    function automatic logic [7:0] byte_at(input logic [UB*8-1:0] v, input int idx);
        byte_at = v[(UB-1-idx)*8 +: 8];
    endfunction

    assign s = i_ev.set_desc;
    assign d = i_ev.field_desc;

    always_comb begin
        rec = '0;
        rec.kind = i_ev.kind;
        rec.set_desc = s;
        rec.field_desc = d;
        rec.last = i_ev.last;
        if (i_ev.kind == spfp_pkg::K_UNKNOWN) begin
            if (d == spfp_pkg::DESC_ACK) begin
                rec.kind = spfp_pkg::K_ACK;
                rec.ack_echo = byte_at(i_bytes, 0);
                rec.ack_error = byte_at(i_bytes, 1);
            end else if ((s == spfp_pkg::SET_NAV && d >= 8'h01 && d <= spfp_pkg::DESC_MAX1)
                      || (s == spfp_pkg::SET_AUX && d == spfp_pkg::DESC_AUX)) begin
                rec.kind = spfp_pkg::K_FLOAT3;
                rec.x_bits = {32'd0, i_bytes[UB*8-1 -: 32]};
                rec.y_bits = {32'd0, i_bytes[UB*8-33 -: 32]};
                rec.z_bits = {32'd0, i_bytes[UB*8-65 -: 32]};
            end else if (s == spfp_pkg::SET_NAV && d == spfp_pkg::DESC_TIME) begin
                rec.kind = spfp_pkg::K_TIME;
                rec.tick_count = i_bytes[UB*8-1 -: 32];
            end else if (s == spfp_pkg::SET_GPS && d == spfp_pkg::DESC_LLH) begin
                rec.kind = spfp_pkg::K_DOUBLE3;
                rec.x_bits = i_bytes[UB*8-1 -: 64];
                rec.y_bits = i_bytes[UB*8-65 -: 64];
                rec.z_bits = i_bytes[UB*8-129 -: 64];
                rec.accuracy_bits = i_bytes[UB*8-193 -: 32];
                rec.valid_flags = i_bytes[UB*8-225 -: 16];
            end else if (s == spfp_pkg::SET_GPS && d == spfp_pkg::DESC_NED) begin
                rec.kind = spfp_pkg::K_FLOAT3A;
                rec.x_bits = {32'd0, i_bytes[UB*8-1 -: 32]};
                rec.y_bits = {32'd0, i_bytes[UB*8-33 -: 32]};
                rec.z_bits = {32'd0, i_bytes[UB*8-65 -: 32]};
                rec.accuracy_bits = i_bytes[UB*8-97 -: 32];
                rec.valid_flags = i_bytes[UB*8-129 -: 16];
            end
        end
    end

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_rec = r_rec;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rec <= rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor packet field parser. Framed packets with
// random fields, error packets and line noise are pushed byte by byte; every
// popped record is compared field by field with a behavioral parser model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES = 32;
    localparam int BUF_AW = $clog2(BUF_BYTES);
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_record_kind;
    logic [7:0]  o_set_desc;
    logic [7:0]  o_field_desc;
    logic [63:0] o_x_bits;
    logic [63:0] o_y_bits;
    logic [63:0] o_z_bits;
    logic [31:0] o_accuracy_bits;
    logic [15:0] o_valid_flags;
    logic [31:0] o_tick_count;
    logic [7:0]  o_ack_echo;
    logic [7:0]  o_ack_error;
    logic        o_last_in_packet;

    sensor_packet_field_parser #(.FIELD_BUF_BYTES(BUF_BYTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_rx_byte(i_rx_byte), .empty(empty), .pop(pop),
        .o_record_kind(o_record_kind), .o_set_desc(o_set_desc),
        .o_field_desc(o_field_desc), .o_x_bits(o_x_bits), .o_y_bits(o_y_bits),
        .o_z_bits(o_z_bits), .o_accuracy_bits(o_accuracy_bits),
        .o_valid_flags(o_valid_flags), .o_tick_count(o_tick_count),
        .o_ack_echo(o_ack_echo), .o_ack_error(o_ack_error),
        .o_last_in_packet(o_last_in_packet)
    );

    logic [7:0]        pending_bytes[$];
    spfp_pkg::t_record expected_records[$];
    int                mismatches = 0;
    int                cycles = 0;
    int                send_idle_pct;
    int                recv_idle_pct;
    bit                hold_for_drain;

    spfp_pkg::t_phase m_phase = spfp_pkg::PH_HUNT;
    logic [7:0] m_set = 8'h00;
    logic [7:0] m_plen = 8'h00;
    logic [7:0] m_ppos = 8'h00;
    logic [7:0] m_flen = 8'h00;
    logic [7:0] m_fdesc = 8'h00;
    logic [7:0] m_fpos = 8'h00;
    logic [7:0] m_fbuf[BUF_BYTES] = '{default: 8'h00};
    logic [1:0] m_trailer = 2'd0;

    task automatic append_byte(logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    task automatic expect_record(spfp_pkg::t_record r);
        expected_records.insert(expected_records.size(), r);
    endtask

    function automatic logic [7:0] field_byte(int idx);
        if (idx >= BUF_BYTES || idx >= m_fpos) return 8'h00;
        return m_fbuf[idx[BUF_AW-1:0]];
    endfunction

    function automatic logic [63:0] field_be(int start, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v = (v << 8) | 64'(field_byte(start + i));
        return v;
    endfunction

    function automatic spfp_pkg::t_record error_record(spfp_pkg::t_kind k, logic [7:0] s,
                                                       logic [7:0] d);
        spfp_pkg::t_record r;
        r = '0;
        r.kind = k;
        r.set_desc = s;
        r.field_desc = d;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic spfp_pkg::t_record field_record(bit last);
        spfp_pkg::t_record r;
        logic [63:0] v;
        r = '0;
        r.kind = spfp_pkg::K_UNKNOWN;
        if (m_fdesc == spfp_pkg::DESC_ACK) begin
            r.kind = spfp_pkg::K_ACK;
            r.ack_echo = field_byte(0);
            r.ack_error = field_byte(1);
        end else if ((m_set == spfp_pkg::SET_NAV && m_fdesc >= 8'h01 &&
                      m_fdesc <= spfp_pkg::DESC_MAX1) ||
                     (m_set == spfp_pkg::SET_AUX && m_fdesc == spfp_pkg::DESC_AUX)) begin
            r.kind = spfp_pkg::K_FLOAT3;
            r.x_bits = field_be(0, 4);
            r.y_bits = field_be(4, 4);
            r.z_bits = field_be(8, 4);
        end else if (m_set == spfp_pkg::SET_NAV && m_fdesc == spfp_pkg::DESC_TIME) begin
            r.kind = spfp_pkg::K_TIME;
            v = field_be(0, 4);
            r.tick_count = v[31:0];
        end else if (m_set == spfp_pkg::SET_GPS && m_fdesc == spfp_pkg::DESC_LLH) begin
            r.kind = spfp_pkg::K_DOUBLE3;
            r.x_bits = field_be(0, 8);
            r.y_bits = field_be(8, 8);
            r.z_bits = field_be(16, 8);
            v = field_be(24, 4);
            r.accuracy_bits = v[31:0];
            v = field_be(28, 2);
            r.valid_flags = v[15:0];
        end else if (m_set == spfp_pkg::SET_GPS && m_fdesc == spfp_pkg::DESC_NED) begin
            r.kind = spfp_pkg::K_FLOAT3A;
            r.x_bits = field_be(0, 4);
            r.y_bits = field_be(4, 4);
            r.z_bits = field_be(8, 4);
            v = field_be(12, 4);
            r.accuracy_bits = v[31:0];
            v = field_be(16, 2);
            r.valid_flags = v[15:0];
        end
        r.set_desc = m_set;
        r.field_desc = m_fdesc;
        r.last = last;
        return r;
    endfunction

    task automatic enter_skip();
        m_trailer = '0;
        m_phase = (m_ppos == m_plen) ? spfp_pkg::PH_TRAILER : spfp_pkg::PH_SKIP;
    endtask

    task automatic parse_byte(logic [7:0] b);
        bit at_end;
        case (m_phase)
            spfp_pkg::PH_SYNC2: begin
                if (b == spfp_pkg::SYNC2) begin
                    m_phase = spfp_pkg::PH_SET;
                end else begin
                    expect_record(error_record(spfp_pkg::K_SYNC_ERR, 8'h00, 8'h00));
                    m_trailer = '0;
                    m_phase = spfp_pkg::PH_TRAILER;
                end
            end
            spfp_pkg::PH_SET: begin
                m_set = b;
                m_phase = spfp_pkg::PH_LEN;
            end
            spfp_pkg::PH_LEN: begin
                m_plen = b;
                m_ppos = '0;
                enter_skip();
                if (b != 8'h00) m_phase = spfp_pkg::PH_FLEN;
            end
            spfp_pkg::PH_FLEN: begin
                m_ppos++;
                m_flen = b;
                m_fdesc = '0;
                if (b < 8'd2) begin
                    expect_record(error_record(spfp_pkg::K_BAD_LEN, m_set, 8'h00));
                    enter_skip();
                end else begin
                    foreach (m_fbuf[i]) m_fbuf[i] = '0;
                    m_fpos = '0;
                    if (m_ppos == m_plen) enter_skip();
                    else m_phase = spfp_pkg::PH_FDESC;
                end
            end
            spfp_pkg::PH_FDESC: begin
                m_ppos++;
                m_fdesc = b;
                at_end = (m_ppos == m_plen);
                if (b != spfp_pkg::DESC_ACK && !(m_set == spfp_pkg::SET_NAV ||
                                                 m_set == spfp_pkg::SET_GPS ||
                                                 m_set == spfp_pkg::SET_AUX)) begin
                    expect_record(error_record(spfp_pkg::K_BAD_SET, m_set, b));
                    enter_skip();
                end else if (m_flen == 8'd2 || at_end) begin
                    expect_record(field_record(at_end));
                    if (at_end) enter_skip();
                    else m_phase = spfp_pkg::PH_FLEN;
                end else begin
                    m_phase = spfp_pkg::PH_FDATA;
                end
            end
            spfp_pkg::PH_FDATA: begin
                m_ppos++;
                if (m_fpos < BUF_BYTES) m_fbuf[m_fpos[BUF_AW-1:0]] = b;
                m_fpos++;
                at_end = (m_ppos == m_plen);
                if (int'(m_fpos) + 2 >= int'(m_flen) || at_end) begin
                    expect_record(field_record(at_end));
                    if (at_end) enter_skip();
                    else m_phase = spfp_pkg::PH_FLEN;
                end
            end
            spfp_pkg::PH_SKIP: begin
                m_ppos++;
                if (m_ppos == m_plen) begin
                    m_trailer = '0;
                    m_phase = spfp_pkg::PH_TRAILER;
                end
            end
            spfp_pkg::PH_TRAILER: begin
                m_trailer = m_trailer + 2'd1;
                if (m_trailer >= 2'd2) begin
                    m_trailer = '0;
                    m_phase = spfp_pkg::PH_HUNT;
                end
            end
            default: m_phase = (b == spfp_pkg::SYNC1) ? spfp_pkg::PH_SYNC2
                                                      : spfp_pkg::PH_HUNT;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        mismatches++;
    endtask

    // Builds one framed packet. Field descriptors and lengths are drawn from the
    // decoded set so that most fields reach the data phase.
    task automatic queue_packet(logic [7:0] set_byte, int nfields, bit allow_bad);
        logic [7:0] payload[$];
        logic [7:0] descs[$];
        int flen;
        int plen;
        logic [7:0] d;
        for (int f = 0; f < nfields; f++) begin
            case (set_byte)
                spfp_pkg::SET_NAV: descs = '{8'h01, 8'h03, spfp_pkg::DESC_MAX1,
                                             spfp_pkg::DESC_TIME, spfp_pkg::DESC_ACK, 8'h09};
                spfp_pkg::SET_GPS: descs = '{spfp_pkg::DESC_LLH, spfp_pkg::DESC_NED,
                                             spfp_pkg::DESC_ACK, 8'h05};
                spfp_pkg::SET_AUX: descs = '{spfp_pkg::DESC_AUX, spfp_pkg::DESC_ACK, 8'h9a};
                default: descs = '{spfp_pkg::DESC_ACK, 8'h01};
            endcase
            d = descs[$urandom_range(0, descs.size() - 1)];
            if ($urandom_range(0, 9) == 0) d = 8'($urandom);
            case ($urandom_range(0, 5))
                0: flen = 2;
                1: flen = $urandom_range(3, 12);
                2: flen = $urandom_range(30, 40);
                default: flen = (d == spfp_pkg::DESC_LLH) ? 32 :
                                (d == spfp_pkg::DESC_NED) ? 20 : 14;
            endcase
            if (allow_bad && $urandom_range(0, 15) == 0) flen = $urandom_range(0, 1);
            payload.insert(payload.size(), flen[7:0]);
            payload.insert(payload.size(), d);
            for (int i = 2; i < flen; i++) payload.insert(payload.size(), 8'($urandom));
        end
        plen = payload.size();
        if (allow_bad && $urandom_range(0, 7) == 0 && plen > 1)
            plen = $urandom_range(1, plen);
        if (plen > 255) plen = 255;
        append_byte(spfp_pkg::SYNC1);
        append_byte(spfp_pkg::SYNC2);
        append_byte(set_byte);
        append_byte(plen[7:0]);
        for (int i = 0; i < plen; i++) append_byte(payload[i]);
        append_byte(8'($urandom));
        append_byte(8'($urandom));
    endtask

    task automatic queue_random(int budget);
        int start;
        int r;
        logic [7:0] sets[4];
        sets = '{spfp_pkg::SET_NAV, spfp_pkg::SET_GPS, spfp_pkg::SET_AUX, 8'h00};
        start = pending_bytes.size();
        while (pending_bytes.size() - start < budget) begin
            r = $urandom_range(0, 19);
            if (r < 15) begin
                queue_packet(sets[2'($urandom_range(0, 2))], $urandom_range(1, 4), 1'b1);
            end else if (r < 17) begin
                queue_packet(8'($urandom), $urandom_range(1, 2), 1'b1);
            end else if (r < 18) begin
                append_byte(spfp_pkg::SYNC1);
                append_byte(8'($urandom));
                append_byte(8'($urandom));
                append_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            push <= 1'b0;
            i_rx_byte <= '0;
        end else begin
            if (push && !full) parse_byte(i_rx_byte);
            if ((push && full) ||
                (pending_bytes.size() > 0 && !hold_for_drain &&
                 $urandom_range(0, 99) >= send_idle_pct)) begin
                if (!(push && full)) begin
                    push <= 1'b1;
                    i_rx_byte <= pending_bytes.pop_front();
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("unexpected record", 64'(o_record_kind), 64'd0);
                end else begin
                    spfp_pkg::t_record e;
                    e = expected_records.pop_front();
                    if (o_record_kind != e.kind)
                        report_mismatch("kind", 64'(o_record_kind), 64'(e.kind));
                    if (o_set_desc != e.set_desc)
                        report_mismatch("set", 64'(o_set_desc), 64'(e.set_desc));
                    if (o_field_desc != e.field_desc)
                        report_mismatch("field desc", 64'(o_field_desc), 64'(e.field_desc));
                    if (o_x_bits != e.x_bits) report_mismatch("x", o_x_bits, e.x_bits);
                    if (o_y_bits != e.y_bits) report_mismatch("y", o_y_bits, e.y_bits);
                    if (o_z_bits != e.z_bits) report_mismatch("z", o_z_bits, e.z_bits);
                    if (o_accuracy_bits != e.accuracy_bits)
                        report_mismatch("accuracy", 64'(o_accuracy_bits),
                                        64'(e.accuracy_bits));
                    if (o_valid_flags != e.valid_flags)
                        report_mismatch("flags", 64'(o_valid_flags), 64'(e.valid_flags));
                    if (o_tick_count != e.tick_count)
                        report_mismatch("ticks", 64'(o_tick_count), 64'(e.tick_count));
                    if (o_ack_echo != e.ack_echo)
                        report_mismatch("echo", 64'(o_ack_echo), 64'(e.ack_echo));
                    if (o_ack_error != e.ack_error)
                        report_mismatch("error", 64'(o_ack_error), 64'(e.ack_error));
                    if (o_last_in_packet != e.last)
                        report_mismatch("last", 64'(o_last_in_packet), 64'(e.last));
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || push || expected_records.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] ramp[$];
        i_rst_n = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 67;
        hold_for_drain = 1'b0;

        // Directed: ack, float, time and double records with all-ones and ramp data, the error
        // cases, a length-two field, a truncated field, an empty payload and an
        // overlong field that runs past the buffer.
        ramp = '{8'd40, 8'h04};
        for (int i = 0; i < 38; i++) ramp = {ramp, ((i % 2) != 0) ? 8'hff : 8'h00};
        pending_bytes = '{spfp_pkg::SYNC1, spfp_pkg::SYNC2, spfp_pkg::SET_GPS, 8'd40};
        foreach (ramp[i]) append_byte(ramp[i]);
        append_byte(8'hff);
        append_byte(8'h00);
        pending_bytes = {pending_bytes, spfp_pkg::SYNC1, spfp_pkg::SYNC2,
            spfp_pkg::SET_NAV, 8'd26,
            8'd4, spfp_pkg::DESC_ACK, 8'hff, 8'h80,
            8'd14, 8'h01, 8'h3f, 8'h80, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
            8'h01, 8'h02, 8'h03, 8'h04,
            8'd6, spfp_pkg::DESC_TIME, 8'hde, 8'had, 8'hbe, 8'hef,
            8'd2, 8'h09, 8'h00, 8'h00};
        pending_bytes = {pending_bytes, spfp_pkg::SYNC1, 8'h00, 8'h11, 8'h22,
            spfp_pkg::SYNC1, spfp_pkg::SYNC2, 8'h55, 8'd3, 8'd3, 8'h01, 8'h07,
            8'h00, 8'h00,
            spfp_pkg::SYNC1, spfp_pkg::SYNC2, spfp_pkg::SET_AUX, 8'd5, 8'd1,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            spfp_pkg::SYNC1, spfp_pkg::SYNC2, spfp_pkg::SET_AUX, 8'd0, 8'h00, 8'h00,
            spfp_pkg::SYNC1, spfp_pkg::SYNC2, spfp_pkg::SET_AUX, 8'd4, 8'd14,
            spfp_pkg::DESC_AUX, 8'h12, 8'h34, 8'h00, 8'h00,
            spfp_pkg::SYNC1, spfp_pkg::SYNC2, spfp_pkg::SET_GPS, 8'd1, 8'd20,
            8'h00, 8'hff};
        queue_packet(spfp_pkg::SET_GPS, 1, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_random(550);
        repeat (300) @(posedge i_clk);

        // Hold the sender until every expected record has come out.
        hold_for_drain = 1'b1;
        @(posedge i_clk);
        while (push || expected_records.size() > 0) @(posedge i_clk);
        hold_for_drain = 1'b0;
        wait_drained();

        send_idle_pct = 67;
        recv_idle_pct = 9;
        queue_random(550);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(550);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
